/* rtl/core/keyed_slot_table_unit_defines.svh */
// Assertion macros shared by the keyed slot table checker.
`ifndef KEYED_SLOT_TABLE_UNIT_DEFINES_SVH
`define KEYED_SLOT_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while rst is high.
`define KST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off while rst is high.
`define KST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/kst_pkg.sv */
// Package for the keyed slot table: sizes, codes, structs and width helpers.
package kst_pkg;

  localparam int SLOTS     = 32;
  localparam int KEY_BITS  = 16;
  localparam int DATA_BITS = 32;
  localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Fixed widths of the transaction fields at the ports
  localparam int KEY_PORT_W  = 16;
  localparam int DATA_PORT_W = 32;
  localparam int SLOT_PORT_W = 5;

  localparam longint unsigned FIRST_ID_RESET = 64'd100;
  localparam longint unsigned KEY_MASK_L     = (64'd1 << KEY_BITS) - 64'd1;
  localparam logic [KEY_BITS:0] NEXT_KEY_RESET =
    (KEY_BITS + 1)'(FIRST_ID_RESET & KEY_MASK_L);

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CHANGE = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_FIND   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

  // Priority chain passed from cell to cell, lowest slot first
  typedef struct packed {
    logic                 hit_seen;
    logic                 free_seen;
    logic [SLOT_BITS-1:0] idx;
    logic [DATA_BITS-1:0] data;
  } chain_t;

  // Update broadcast to every cell
  typedef struct packed {
    logic                 use_free;
    logic                 add_go;
    logic                 chg_go;
    logic                 rem_go;
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] data;
  } upd_t;

  function automatic logic [KEY_BITS-1:0] port_to_key(input logic [KEY_PORT_W-1:0] v);
    logic [KEY_BITS+KEY_PORT_W-1:0] w;
    w = {{KEY_BITS{1'b0}}, v};
    return w[KEY_BITS-1:0];
  endfunction

  function automatic logic [KEY_PORT_W-1:0] key_to_port(input logic [KEY_BITS-1:0] v);
    logic [KEY_BITS+KEY_PORT_W-1:0] w;
    w = {{KEY_PORT_W{1'b0}}, v};
    return w[KEY_PORT_W-1:0];
  endfunction

  function automatic logic [DATA_BITS-1:0] port_to_data(input logic [DATA_PORT_W-1:0] v);
    logic [DATA_BITS+DATA_PORT_W-1:0] w;
    w = {{DATA_BITS{1'b0}}, v};
    return w[DATA_BITS-1:0];
  endfunction

  function automatic logic [DATA_PORT_W-1:0] data_to_port(input logic [DATA_BITS-1:0] v);
    logic [DATA_BITS+DATA_PORT_W-1:0] w;
    w = {{DATA_PORT_W{1'b0}}, v};
    return w[DATA_PORT_W-1:0];
  endfunction

  function automatic logic [SLOT_PORT_W-1:0] slot_to_port(input logic [SLOT_BITS-1:0] v);
    logic [SLOT_BITS+SLOT_PORT_W-1:0] w;
    w = {{SLOT_PORT_W{1'b0}}, v};
    return w[SLOT_PORT_W-1:0];
  endfunction

endpackage

/* rtl/core/keyed_slot_table_unit.sv */
// The slot row latches its compare when an input transaction is accepted, and the priority chain
// picks, updates and loads the result into the output register in the pick state.
// A new transaction is stalled (in_stall) until the pick state is left, so only one is in flight;
// the sequencer returns to idle once the result is loaded.
// A full output register holds the pick cycle until the result is taken.
// Reset (rst, synchronous): every slot free, identifier counter at 100, no result.
module keyed_slot_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [15:0] key_id,
  input  logic [31:0] payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [4:0]  slot,
  output logic [15:0] entry_id,
  output logic [31:0] entry_data
);

  localparam int Slots    = kst_pkg::SLOTS;
  localparam int KeyBits  = kst_pkg::KEY_BITS;
  localparam int DataBits = kst_pkg::DATA_BITS;
  localparam int SlotBits = kst_pkg::SLOT_BITS;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_PICK = 2'b10
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic                   accept;
  logic                   advance;
  kst_pkg::cmd_t          req_cmd;
  logic [KeyBits-1:0]     req_key;
  logic [DataBits-1:0]    req_payload;
  logic [KeyBits:0]       next_key;
  logic                   exhausted;
  kst_pkg::upd_t          upd;
  kst_pkg::chain_t        chain [0:Slots];
  kst_pkg::chain_t        tail;
  kst_pkg::status_t       res_status;
  logic [4:0]             res_slot;
  logic [15:0]            res_id;
  logic [31:0]            res_data;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign advance  = (state == S_PICK) && (!out_valid || !out_stall);

  // Sequencer: take a transaction, then pick and update
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_PICK;
      S_PICK:  if (advance) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the request fields for the pick cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd     <= kst_pkg::cmd_t'(cmd);
      req_key     <= kst_pkg::port_to_key(key_id);
      req_payload <= kst_pkg::port_to_data(payload);
    end
  end

  // Slot row with the priority chain running from slot 0 upward
  assign chain[0] = '0;

  for (genvar g = 0; g < Slots; g++) begin : g_cell
    kst_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .look      (accept),
      .look_key  (kst_pkg::port_to_key(key_id)),
      .upd       (upd),
      .cell_idx  (SlotBits'(g)),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1])
    );
  end

  assign tail      = chain[Slots];
  assign exhausted = next_key[KeyBits];

  // Broadcast the update to the row
  always_comb begin
    upd.use_free = (req_cmd == kst_pkg::CMD_ADD);
    upd.add_go   = advance && (req_cmd == kst_pkg::CMD_ADD) && !exhausted && tail.free_seen;
    upd.chg_go   = advance && (req_cmd == kst_pkg::CMD_CHANGE) && tail.hit_seen;
    upd.rem_go   = advance && (req_cmd == kst_pkg::CMD_REMOVE) && tail.hit_seen;
    upd.key      = next_key[KeyBits-1:0];
    upd.data     = req_payload;
  end

  // Identifier counter: reload on a register write, advance on a successful add
  always_ff @(posedge clk) begin
    if (rst) begin
      next_key <= kst_pkg::NEXT_KEY_RESET;
    end else if (cfg_we) begin
      next_key <= {1'b0, kst_pkg::port_to_key(cfg_wdata)};
    end else if (upd.add_go) begin
      next_key <= next_key + {{KeyBits{1'b0}}, 1'b1};
    end
  end

  // Form the result
  always_comb begin
    res_status = kst_pkg::ST_OK;
    res_slot   = '0;
    res_id     = '0;
    res_data   = '0;
    case (req_cmd)
      kst_pkg::CMD_ADD: begin
        if (exhausted) begin
          res_status = kst_pkg::ST_EXHAUSTED;
        end else if (!tail.free_seen) begin
          res_status = kst_pkg::ST_FULL;
        end else begin
          res_slot = kst_pkg::slot_to_port(tail.idx);
          res_id   = kst_pkg::key_to_port(next_key[KeyBits-1:0]);
        end
      end
      default: begin
        res_id = kst_pkg::key_to_port(req_key);
        if (!tail.hit_seen) begin
          res_status = kst_pkg::ST_NOT_FOUND;
        end else begin
          res_slot = kst_pkg::slot_to_port(tail.idx);
          if (req_cmd == kst_pkg::CMD_FIND) begin
            res_data = kst_pkg::data_to_port(tail.data);
          end
        end
      end
    endcase
  end

  // Output register: load on pick, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status     <= res_status;
      slot       <= res_slot;
      entry_id   <= res_id;
      entry_data <= res_data;
    end
  end

endmodule

/* rtl/core/kst_cell.sv */
// One table slot: used flag, identifier, payload and its link in the priority chain.
module kst_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           look,
  input  logic [kst_pkg::KEY_BITS-1:0]   look_key,
  input  kst_pkg::upd_t                  upd,
  input  logic [kst_pkg::SLOT_BITS-1:0]  cell_idx,
  input  kst_pkg::chain_t                chain_in,
  output kst_pkg::chain_t                chain_out
);

  logic                           used;
  logic [kst_pkg::KEY_BITS-1:0]   key;
  logic [kst_pkg::DATA_BITS-1:0]  data;
  logic                           hit;
  logic                           free;
  logic                           sel_hit;
  logic                           sel_free;
  logic                           sel;

  // Latch the compare result when a transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      hit  <= 1'b0;
      free <= 1'b0;
    end else if (look) begin
      hit  <= used && (key == look_key);
      free <= !used;
    end
  end

  // Claim this slot only if no lower slot has claimed already
  assign sel_hit  = hit  && !chain_in.hit_seen;
  assign sel_free = free && !chain_in.free_seen;
  assign sel      = upd.use_free ? sel_free : sel_hit;

  // Advance the chain to the next slot
  always_comb begin
    chain_out.hit_seen  = chain_in.hit_seen  | hit;
    chain_out.free_seen = chain_in.free_seen | free;
    chain_out.idx       = chain_in.idx  | (sel ? cell_idx : '0);
    chain_out.data      = chain_in.data | (sel_hit ? data : '0);
  end

  // Occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (upd.add_go && sel_free) begin
      used <= 1'b1;
    end else if (upd.rem_go && sel_hit) begin
      used <= 1'b0;
    end
  end

  // Identifier and payload storage
  always_ff @(posedge clk) begin
    if (upd.add_go && sel_free) begin
      key  <= upd.key;
      data <= upd.data;
    end else if (upd.chg_go && sel_hit) begin
      data <= upd.data;
    end
  end

endmodule

/* rtl/core/kst_check.sv */
// Port-level checker for the keyed slot table, bound to the top level.
`include "keyed_slot_table_unit_defines.svh"

module kst_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [4:0]  slot,
  input logic [15:0] entry_id,
  input logic [31:0] entry_data
);

  `KST_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(slot) && $stable(entry_id) && $stable(entry_data), "stalled result changed")
  `KST_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "second transaction taken during pick")
  `KST_ASSERT_NOW(a_fail_slot_zero, out_valid && (status != kst_pkg::ST_OK), slot == 5'd0, "slot not zero on failure")
  `KST_ASSERT_NOW(a_fail_data_zero, out_valid && (status != kst_pkg::ST_OK), entry_data == 32'd0, "data not zero on failure")
  `KST_ASSERT_NOW(a_add_fail_id_zero, out_valid && ((status == kst_pkg::ST_FULL) || (status == kst_pkg::ST_EXHAUSTED)), entry_id == 16'd0, "identifier not zero on failed add")

endmodule

bind keyed_slot_table_unit kst_check u_kst_check (.*);
